[hw/rtl/tcce_pkg.sv]
// Shared types and constants for the text console cursor engine.
// No dependencies; every other file of the block imports this package.
package tcce_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;
  localparam int QUEUE_DEPTH = 4;
  localparam int TAB_STEP    = 4;

  localparam logic [1:0] CMD_PUT    = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_SETCUR = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;

  localparam logic [3:0] FORE_RESET = 4'd15;
  localparam logic [3:0] BACK_RESET = 4'd0;

  localparam logic REG_FORE = 1'b0;
  localparam logic REG_BACK = 1'b1;

  localparam logic [2:0] K_PRINT   = 3'd0;
  localparam logic [2:0] K_NEWLINE = 3'd1;
  localparam logic [2:0] K_TAB     = 3'd2;
  localparam logic [2:0] K_BACKSP  = 3'd3;
  localparam logic [2:0] K_CLEAR   = 3'd4;
  localparam logic [2:0] K_SETCUR  = 3'd5;
  localparam logic [2:0] K_READ    = 3'd6;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] char_code;
    logic [4:0] row;
    logic [6:0] col;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [10:0] cursor_index;
    logic [7:0]  read_char;
    logic [3:0]  read_fore;
    logic [3:0]  read_back;
  } out_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic [4:0] row;
    logic [6:0] col;
  } op_t;

  typedef struct packed {
    logic pop;
    logic hold_in;
  } q_ctrl_t;

endpackage

[hw/rtl/tcce_front.sv]
// Front end: accepts commands, classifies them, saturates coordinates
// and queues them for the back end. Depends on tcce_pkg.
module tcce_front import tcce_pkg::*; #(
  parameter int ROWS    = ROWS_DEF,
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int QDEPTH  = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     q_valid,
  output op_t      q_head,
  input  q_ctrl_t  q_ctrl
);

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);
  localparam logic [QAW-1:0] PTR_LAST = QAW'(QDEPTH - 1);
  localparam logic [QCW-1:0] CNT_FULL = QCW'(QDEPTH);

  op_t            queue_r [QDEPTH];
  logic [QAW-1:0] wptr_r, wptr_nxt;
  logic [QAW-1:0] rptr_r, rptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  op_t            op_in;
  logic           push;

  always_comb begin
    op_in.ch  = in_data.char_code;
    op_in.row = (32'(in_data.row) >= ROWS) ? 5'(ROWS - 1) : in_data.row;
    op_in.col = (32'(in_data.col) >= COLUMNS) ? 7'(COLUMNS - 1) : in_data.col;
    unique case (in_data.cmd)
      CMD_PUT: begin
        unique case (in_data.char_code)
          CH_NEWLINE:   op_in.kind = K_NEWLINE;
          CH_TAB:       op_in.kind = K_TAB;
          CH_BACKSPACE: op_in.kind = K_BACKSP;
          default:      op_in.kind = K_PRINT;
        endcase
      end
      CMD_CLEAR:  op_in.kind = K_CLEAR;
      CMD_SETCUR: op_in.kind = K_SETCUR;
      default:    op_in.kind = K_READ;
    endcase
  end

  assign in_stall = (cnt_r == CNT_FULL) || q_ctrl.hold_in;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_head   = queue_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_LAST) ? '0 : wptr_r + 1'b1;
    end
    if (q_ctrl.pop) begin
      rptr_nxt = (rptr_r == PTR_LAST) ? '0 : rptr_r + 1'b1;
    end
    if (push && !q_ctrl.pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_ctrl.pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wptr_r] <= op_in;
    end
  end

endmodule

[hw/rtl/tcce_back.sv]
// Back end: screen store, cursor, colour registers, scroll and clear
// sweeps, and the result register. Depends on tcce_pkg.
module tcce_back import tcce_pkg::*; #(
  parameter int ROWS    = ROWS_DEF,
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  op_t       q_head,
  output q_ctrl_t   q_ctrl,
  input  logic      cfg_valid,
  input  logic      cfg_index,
  input  logic [3:0] cfg_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int IW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);

  localparam logic [IW-1:0] CELL_LAST = IW'(CELLS - 1);
  localparam logic [IW-1:0] SCR_END   = IW'((ROWS - 1) * COLUMNS);
  localparam logic [IW-1:0] COL_STEP  = IW'(COLUMNS);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
  localparam logic [CW:0]   COL_LIM   = (CW + 1)'(COLUMNS);
  localparam logic [CW:0]   TAB_MASK  = (CW + 1)'(TAB_STEP - 1);
  localparam logic [15:0]   BLANK_RST = {BACK_RESET, FORE_RESET, CH_SPACE};

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCROLL = 3'd2;
  localparam logic [2:0] ST_BLANK  = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [15:0]   mem [CELLS];
  logic [15:0]   rd_data_r;
  logic          we, re;
  logic [IW-1:0] wa, ra;
  logic [15:0]   wd;

  logic [2:0]    st_r, st_nxt;
  logic [IW-1:0] sw_r, sw_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic          clr_cmd_r, clr_cmd_nxt;
  logic          rd_op_r, rd_op_nxt;
  logic [3:0]    fore_r, back_r;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  logic [IW-1:0] cur_idx, tgt_idx;
  logic [CW:0]   col_inc, tab_col;
  logic [15:0]   blank;
  logic          last_row;
  logic          out_free;

  assign cur_idx  = IW'(row_r * COLUMNS) + IW'(col_r);
  assign tgt_idx  = IW'(q_head.row * COLUMNS) + IW'(q_head.col);
  assign col_inc  = {1'b0, col_r} + 1'b1;
  assign tab_col  = ({1'b0, col_r} | TAB_MASK) + 1'b1;
  assign blank    = {back_r, fore_r, CH_SPACE};
  assign last_row = (row_r == ROW_LAST);
  assign out_free = !out_valid_r || !out_stall;

  assign q_ctrl.pop     = q_valid && (st_r == ST_IDLE);
  assign q_ctrl.hold_in = (st_r == ST_CLEAR) && !clr_cmd_r;

  always_comb begin
    st_nxt        = st_r;
    sw_nxt        = sw_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    clr_cmd_nxt   = clr_cmd_r;
    rd_op_nxt     = rd_op_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    we = 1'b0;
    wa = cur_idx;
    wd = blank;
    re = 1'b0;
    ra = tgt_idx;

    unique case (st_r)
      ST_CLEAR: begin
        we = 1'b1;
        wa = sw_r;
        wd = clr_cmd_r ? blank : BLANK_RST;
        sw_nxt = sw_r + 1'b1;
        if (sw_r == CELL_LAST) begin
          st_nxt = clr_cmd_r ? ST_RESULT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          st_nxt    = ST_RESULT;
          rd_op_nxt = 1'b0;
          unique case (q_head.kind)
            K_PRINT: begin
              we = 1'b1;
              wd = {back_r, fore_r, q_head.ch};
              if (col_inc >= COL_LIM) begin
                col_nxt = '0;
                if (last_row) begin
                  st_nxt = ST_SCROLL;
                  sw_nxt = '0;
                end else begin
                  row_nxt = row_r + 1'b1;
                end
              end else begin
                col_nxt = col_inc[CW-1:0];
              end
            end
            K_NEWLINE: begin
              col_nxt = '0;
              if (last_row) begin
                st_nxt = ST_SCROLL;
                sw_nxt = '0;
              end else begin
                row_nxt = row_r + 1'b1;
              end
            end
            K_TAB: begin
              if (tab_col >= COL_LIM) begin
                col_nxt = '0;
                if (last_row) begin
                  st_nxt = ST_SCROLL;
                  sw_nxt = '0;
                end else begin
                  row_nxt = row_r + 1'b1;
                end
              end else begin
                col_nxt = tab_col[CW-1:0];
              end
            end
            K_BACKSP: begin
              if (col_r != '0) begin
                we      = 1'b1;
                wa      = cur_idx - 1'b1;
                col_nxt = col_r - 1'b1;
              end
            end
            K_CLEAR: begin
              st_nxt      = ST_CLEAR;
              sw_nxt      = '0;
              clr_cmd_nxt = 1'b1;
              row_nxt     = '0;
              col_nxt     = '0;
            end
            K_SETCUR: begin
              row_nxt = RW'(q_head.row);
              col_nxt = CW'(q_head.col);
            end
            K_READ: begin
              re        = 1'b1;
              rd_op_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCROLL: begin
        re = (sw_r != SCR_END);
        ra = sw_r + COL_STEP;
        we = (sw_r != '0);
        wa = sw_r - 1'b1;
        wd = rd_data_r;
        if (sw_r == SCR_END) begin
          st_nxt = ST_BLANK;
        end else begin
          sw_nxt = sw_r + 1'b1;
        end
      end
      ST_BLANK: begin
        we = 1'b1;
        wa = sw_r;
        sw_nxt = sw_r + 1'b1;
        if (sw_r == CELL_LAST) begin
          st_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          st_nxt                    = ST_IDLE;
          clr_cmd_nxt               = 1'b0;
          out_valid_nxt             = 1'b1;
          out_data_nxt.cursor_row   = 5'(row_r);
          out_data_nxt.cursor_col   = 7'(col_r);
          out_data_nxt.cursor_index = 11'(cur_idx);
          out_data_nxt.read_char    = rd_op_r ? rd_data_r[7:0] : '0;
          out_data_nxt.read_fore    = rd_op_r ? rd_data_r[11:8] : '0;
          out_data_nxt.read_back    = rd_op_r ? rd_data_r[15:12] : '0;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      sw_r        <= '0;
      row_r       <= '0;
      col_r       <= '0;
      clr_cmd_r   <= 1'b0;
      rd_op_r     <= 1'b0;
      out_valid_r <= 1'b0;
      fore_r      <= FORE_RESET;
      back_r      <= BACK_RESET;
    end else begin
      st_r        <= st_nxt;
      sw_r        <= sw_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      clr_cmd_r   <= clr_cmd_nxt;
      rd_op_r     <= rd_op_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && (cfg_index == REG_FORE)) begin
        fore_r <= cfg_data;
      end
      if (cfg_valid && (cfg_index == REG_BACK)) begin
        back_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/text_console_cursor_engine_unit.sv]
// Top level of the text console cursor engine: front end, command queue
// and back end joined. Depends on tcce_pkg, tcce_front and tcce_back.
//
// Text console with a ROWS x COLUMNS screen store and a cursor; every command
// returns one beat holding the cursor and, for a read, the cell read. After
// reset the store is blanked one cell per cycle and in_stall stays high
// meanwhile; configuration writes are taken at any time. Commands pass a
// four-entry queue to the back end, which runs them one at a time against a
// screen store with one read and one write port; a clear screen blanks the
// store one cell per cycle, and a put character that leaves the last row
// adds a scroll that moves each row up by one and blanks the last row.
module text_console_cursor_engine_unit import tcce_pkg::*; #(
  parameter int ROWS    = ROWS_DEF,
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [3:0] cfg_data
);

  logic    q_valid;
  op_t     q_head;
  q_ctrl_t q_ctrl;

  assign cfg_ready = 1'b1;

  tcce_front #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS),
    .QDEPTH  (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_ctrl   (q_ctrl)
  );

  tcce_back #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_ctrl    (q_ctrl),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
